FILE: design/mzc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mzc_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 32;
  localparam int unsigned DEF_MAX_HEIGHT = 32;

  localparam int unsigned DIM_W   = 6;
  localparam int unsigned COORD_W = 5;
  localparam int unsigned SETS_W  = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  localparam logic DIR_WEST  = 1'b0;
  localparam logic DIR_NORTH = 1'b1;

  // 0 acts as 1, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/mzc_label_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mzc_label_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/mzc_edge_dec.sv
`timescale 1ns / 1ps
`default_nettype none

module mzc_edge_dec #(
  parameter int unsigned MAX_WIDTH = mzc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned AW        = 10
) (
  input  wire logic [mzc_pkg::COORD_W-1:0] cell_x,
  input  wire logic [mzc_pkg::COORD_W-1:0] cell_y,
  input  wire logic                        wall_dir,
  input  wire logic [mzc_pkg::DIM_W-1:0]   width,
  input  wire logic [mzc_pkg::DIM_W-1:0]   height,
  output logic                             bad,
  output logic      [AW-1:0]               addr_a,
  output logic      [AW-1:0]               addr_b
);

  logic [mzc_pkg::COORD_W-1:0] nx;
  logic [mzc_pkg::COORD_W-1:0] ny;

  always_comb begin
    bad = (mzc_pkg::DIM_W'(cell_x) >= width) || (mzc_pkg::DIM_W'(cell_y) >= height) ||
          (wall_dir == mzc_pkg::DIR_WEST && cell_x == '0) ||
          (wall_dir == mzc_pkg::DIR_NORTH && cell_y == '0);
    nx = (wall_dir == mzc_pkg::DIR_WEST) ? cell_x - 1'b1 : cell_x;
    ny = (wall_dir == mzc_pkg::DIR_NORTH) ? cell_y - 1'b1 : cell_y;
    // only used when in range, so the address stays below the store depth
    addr_a = AW'(32'(cell_y) * MAX_WIDTH + 32'(cell_x));
    addr_b = AW'(32'(ny) * MAX_WIDTH + 32'(nx));
  end

endmodule

`default_nettype wire

FILE: design/maze_edge_union_find_carver_core.sv
// Start transaction: rewrites the label store one entry a cycle, each entry to its own index.
// Edge transaction: ends after the decode outside the grid, after both label reads when
// labels match; a carved wall adds one relabel pass over the label store, one entry per cycle.
// Throughput: one transaction at a time; the label store's single read port sets the pace.
// Reset: synchronous active-low; afterwards a clearing pass over every label store entry
// runs with in_ready low. Config writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module maze_edge_union_find_carver_core #(
  parameter int unsigned MAX_WIDTH  = mzc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = mzc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          cfg_we,
  input  wire logic [mzc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mzc_pkg::DIM_W-1:0]     cfg_data,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [mzc_pkg::COORD_W-1:0]   in_cell_x,
  input  wire logic [mzc_pkg::COORD_W-1:0]   in_cell_y,
  input  wire logic                          in_wall_dir,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_carve,
  output logic                               out_bad_edge,
  output logic [mzc_pkg::SETS_W-1:0]         out_sets_remaining
);

  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CNT_W = $clog2(CELLS + 1);
  localparam logic [AW-1:0]    LAST_IDX  = AW'(CELLS - 1);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(CELLS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DEC, S_RDB, S_CMP, S_SWEEP, S_DRAIN, S_DONE
  } state_t;

  state_t                      state_r;
  logic [mzc_pkg::DIM_W-1:0]   grid_width_r;
  logic [mzc_pkg::DIM_W-1:0]   grid_height_r;
  logic [mzc_pkg::DIM_W-1:0]   w_cl;
  logic [mzc_pkg::DIM_W-1:0]   h_cl;
  logic [AW-1:0]               idx_r;
  logic [AW-1:0]               paddr_r;
  logic                        from_start_r;
  logic [CNT_W-1:0]            set_count_r;
  logic [CNT_W-1:0]            count_dec;
  logic [mzc_pkg::COORD_W-1:0] x_r;
  logic [mzc_pkg::COORD_W-1:0] y_r;
  logic                        dir_r;
  logic [AW-1:0]               la_r;
  logic [AW-1:0]               lb_r;
  logic                        res_carve_r;
  logic                        res_bad_r;
  logic                        out_valid_r;
  logic                        out_carve_r;
  logic                        out_bad_edge_r;
  logic [mzc_pkg::SETS_W-1:0]  out_sets_r;

  logic                        dec_bad;
  logic [AW-1:0]               addr_a;
  logic [AW-1:0]               addr_b;

  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [AW-1:0]               mem_wd;
  logic [AW-1:0]               mem_ra;
  logic [AW-1:0]               mem_rd;

  assign w_cl      = mzc_pkg::clamp_dim(grid_width_r, MAX_WIDTH);
  assign h_cl      = mzc_pkg::clamp_dim(grid_height_r, MAX_HEIGHT);
  assign count_dec = (set_count_r != '0) ? set_count_r - 1'b1 : set_count_r;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_carve          = out_carve_r;
  assign out_bad_edge       = out_bad_edge_r;
  assign out_sets_remaining = out_sets_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= mzc_pkg::DIM_RESET;
      grid_height_r <= mzc_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mzc_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        mzc_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mzc_edge_dec #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_dec (
    .cell_x   (x_r),
    .cell_y   (y_r),
    .wall_dir (dir_r),
    .width    (w_cl),
    .height   (h_cl),
    .bad      (dec_bad),
    .addr_a   (addr_a),
    .addr_b   (addr_b)
  );

  // sweep reads entry k while writing entry k-1, so no entry is read and written at once
  always_comb begin
    mem_we = 1'b0;
    mem_wa = paddr_r;
    mem_wd = la_r;
    mem_ra = idx_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_r;
        mem_wd = idx_r;
      end
      S_DEC: mem_ra = addr_a;
      S_RDB: mem_ra = addr_b;
      S_SWEEP: mem_we = (idx_r != '0) && (mem_rd == lb_r);
      S_DRAIN: mem_we = (mem_rd == lb_r);
      default: ;
    endcase
  end

  mzc_label_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      idx_r        <= '0;
      from_start_r <= 1'b0;
      set_count_r  <= CNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            idx_r       <= '0;
            res_carve_r <= 1'b0;
            res_bad_r   <= 1'b0;
            state_r     <= from_start_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            x_r   <= in_cell_x;
            y_r   <= in_cell_y;
            dir_r <= in_wall_dir;
            if (in_op == mzc_pkg::OP_START) begin
              set_count_r  <= CNT_W'(w_cl) * CNT_W'(h_cl);
              from_start_r <= 1'b1;
              idx_r        <= '0;
              state_r      <= S_CLEAR;
            end else begin
              state_r <= S_DEC;
            end
          end
        end
        S_DEC: begin
          res_carve_r <= 1'b0;
          res_bad_r   <= dec_bad;
          state_r     <= dec_bad ? S_DONE : S_RDB;
        end
        S_RDB: begin
          la_r    <= mem_rd;
          state_r <= S_CMP;
        end
        S_CMP: begin
          lb_r  <= mem_rd;
          idx_r <= '0;
          state_r <= (mem_rd == la_r) ? S_DONE : S_SWEEP;
        end
        S_SWEEP: begin
          paddr_r <= idx_r;
          idx_r   <= idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          idx_r       <= '0;
          set_count_r <= count_dec;
          res_carve_r <= 1'b1;
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_carve_r    <= res_carve_r;
            out_bad_edge_r <= res_bad_r;
            out_sets_r     <= mzc_pkg::SETS_W'(set_count_r);
            from_start_r   <= 1'b0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_carve_and_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_carve_r && out_bad_edge_r))
    else $error("carve and bad_edge both set");

  a_sweep_labels_differ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP || state_r == S_DRAIN) |-> (la_r != lb_r))
    else $error("relabel pass with equal labels");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    set_count_r <= CNT_RESET)
    else $error("set count above cell count");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

  a_carve_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_DONE && res_carve_r))
    else $error("relabel pass did not end in a carve");

endmodule

`default_nettype wire
